>>> rtl/core/block_rms_level_meter_defines.svh
// Assertion macros used by the level meter datapath.
`ifndef BLOCK_RMS_LEVEL_METER_DEFINES_SVH
`define BLOCK_RMS_LEVEL_METER_DEFINES_SVH

`ifndef ASSERT_OFF

`define RLM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlm: assertion failed");

`define RLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlm: assertion failed");

`else

`define RLM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define RLM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/rlm_pkg.sv
package rlm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int HEIGHT_W   = 9;
    localparam int FC_W       = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int MAX_BLOCK_FRAMES = 8191;
    localparam int HEIGHT_SCALE     = 76;

    localparam int K2   = HEIGHT_SCALE * HEIGHT_SCALE;
    localparam int K2_W = $clog2(K2 + 1);

    // magnitude of a sample, its square and the block sum of squares
    localparam int MAG_W  = SAMPLE_W;
    localparam int SQS_W  = 2 * MAG_W - 1;
    localparam int SUM_W  = SQS_W + FC_W - 1;
    localparam int WORD_W = 32;
    localparam int SUM_HI_W = SUM_W - WORD_W;
    localparam int RLO_W  = WORD_W + K2_W;
    localparam int RHI_W  = SUM_HI_W + K2_W;
    localparam int RHS_W  = SUM_W + K2_W;

    // full-scale reference and trial height products
    localparam int M_BASE_W = 7;
    localparam int M_W      = M_BASE_W + 16;
    localparam int HM_W     = HEIGHT_W + M_W;
    localparam int HSQ_W    = 2 * HM_W;
    localparam int PROD_W   = WORD_W + FC_W;
    localparam int LHS_W    = WORD_W + PROD_W;
    localparam int BIT_W    = $clog2(HEIGHT_W);

    localparam logic [M_BASE_W-1:0] M_STEREO = 7'h7F;
    localparam logic [M_BASE_W-1:0] M_SINGLE = 7'h3F;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES  = 3'd4;

    localparam logic [1:0] CHANNELS_STEREO = 2'd2;
    localparam logic [1:0] BYTES_ONE       = 2'd1;
    localparam logic [1:0] BYTES_TWO       = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_RHS_LO,
        ST_RHS_HI,
        ST_RHS_SUM,
        ST_HM,
        ST_SQ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_ACCUM,
        OP_RHS_LO,
        OP_RHS_HI,
        OP_RHS_SUM,
        OP_HM,
        OP_SQ,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_CMP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic block_done;
        logic bit_last;
        logic chan_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/rlm_in_if.sv
interface rlm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rlm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/core/rlm_out_if.sv
interface rlm_out_if;
    logic                          valid;
    logic                          ready;
    logic [rlm_pkg::HEIGHT_W-1:0]  left_height;
    logic [rlm_pkg::HEIGHT_W-1:0]  right_height;

    modport source (output valid, output left_height, output right_height, input ready);
    modport sink (input valid, input left_height, input right_height, output ready);
endinterface

>>> rtl/core/rlm_cfg_if.sv
interface rlm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rlm_pkg::CFG_IDX_W-1:0]  index;
    logic [rlm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/rlm_ctrl.sv
module rlm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rlm_pkg::dp_status_t status,
    output rlm_pkg::dp_op_t     op
);

    rlm_pkg::state_t state_reg;
    rlm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rlm_pkg::ST_SQUARE;
                end
            end
            rlm_pkg::ST_SQUARE:  state_next = rlm_pkg::ST_ACCUM;
            rlm_pkg::ST_ACCUM:
            begin
                state_next = status.block_done ? rlm_pkg::ST_RHS_LO : rlm_pkg::ST_IDLE;
            end
            rlm_pkg::ST_RHS_LO:  state_next = rlm_pkg::ST_RHS_HI;
            rlm_pkg::ST_RHS_HI:  state_next = rlm_pkg::ST_RHS_SUM;
            rlm_pkg::ST_RHS_SUM: state_next = rlm_pkg::ST_HM;
            rlm_pkg::ST_HM:      state_next = rlm_pkg::ST_SQ;
            rlm_pkg::ST_SQ:      state_next = rlm_pkg::ST_MUL_LO;
            rlm_pkg::ST_MUL_LO:  state_next = rlm_pkg::ST_MUL_HI;
            rlm_pkg::ST_MUL_HI:  state_next = rlm_pkg::ST_CMP;
            rlm_pkg::ST_CMP:
            begin
                if (!status.bit_last)
                begin
                    state_next = rlm_pkg::ST_HM;
                end
                else if (!status.chan_last)
                begin
                    state_next = rlm_pkg::ST_RHS_LO;
                end
                else
                begin
                    state_next = rlm_pkg::ST_OUT;
                end
            end
            rlm_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = rlm_pkg::ST_IDLE;
                end
            end
            default:             state_next = rlm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        op       = rlm_pkg::OP_NONE;
        case (state_reg)
            rlm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                op       = in_valid ? rlm_pkg::OP_LOAD : rlm_pkg::OP_NONE;
            end
            rlm_pkg::ST_SQUARE:  op = rlm_pkg::OP_SQUARE;
            rlm_pkg::ST_ACCUM:   op = rlm_pkg::OP_ACCUM;
            rlm_pkg::ST_RHS_LO:  op = rlm_pkg::OP_RHS_LO;
            rlm_pkg::ST_RHS_HI:  op = rlm_pkg::OP_RHS_HI;
            rlm_pkg::ST_RHS_SUM: op = rlm_pkg::OP_RHS_SUM;
            rlm_pkg::ST_HM:      op = rlm_pkg::OP_HM;
            rlm_pkg::ST_SQ:      op = rlm_pkg::OP_SQ;
            rlm_pkg::ST_MUL_LO:  op = rlm_pkg::OP_MUL_LO;
            rlm_pkg::ST_MUL_HI:  op = rlm_pkg::OP_MUL_HI;
            rlm_pkg::ST_CMP:     op = rlm_pkg::OP_CMP;
            rlm_pkg::ST_OUT:
            begin
                op = status.out_free ? rlm_pkg::OP_EMIT : rlm_pkg::OP_NONE;
            end
            default:             op = rlm_pkg::OP_NONE;
        endcase
    end

endmodule

>>> rtl/core/rlm_datapath.sv
`include "block_rms_level_meter_defines.svh"

module rlm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rlm_pkg::dp_op_t                     op,
    output rlm_pkg::dp_status_t                 status,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                cfg_valid,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [rlm_pkg::HEIGHT_W-1:0]        left_height,
    output logic [rlm_pkg::HEIGHT_W-1:0]        right_height
);

    localparam int FC_W   = rlm_pkg::FC_W;
    localparam int SUM_W  = rlm_pkg::SUM_W;
    localparam int WORD_W = rlm_pkg::WORD_W;
    localparam int H_W    = rlm_pkg::HEIGHT_W;
    localparam int BIT_W  = rlm_pkg::BIT_W;
    localparam int M_W    = rlm_pkg::M_W;
    localparam int LHS_W  = rlm_pkg::LHS_W;
    localparam int MAG_W  = rlm_pkg::MAG_W;

    localparam logic [rlm_pkg::K2_W-1:0] K2_C = rlm_pkg::K2_W'(rlm_pkg::K2);

    // configuration
    logic             left_en_reg;
    logic             right_en_reg;
    logic [1:0]       chan_count_reg;
    logic [1:0]       sample_bytes_reg;
    logic [FC_W-1:0]  block_frames_reg;

    // accumulation
    logic [MAG_W-1:0]          mag_reg;
    logic [rlm_pkg::SQS_W-1:0] sqs_reg;
    logic [SUM_W-1:0]          lsum_reg;
    logic [SUM_W-1:0]          rsum_reg;
    logic [FC_W-1:0]           fc_reg;
    logic                      phase_reg;

    // height search
    logic                       chan_reg;
    logic [BIT_W-1:0]           bit_reg;
    logic [H_W-1:0]             h_reg;
    logic [rlm_pkg::RLO_W-1:0]  rlo_reg;
    logic [rlm_pkg::RHI_W-1:0]  rhi_reg;
    logic [rlm_pkg::RHS_W-1:0]  rhs_reg;
    logic [rlm_pkg::HM_W-1:0]   hm_reg;
    logic [rlm_pkg::HSQ_W-1:0]  hsq_reg;
    logic [rlm_pkg::PROD_W-1:0] plo_reg;
    logic [rlm_pkg::PROD_W-1:0] phi_reg;
    logic [H_W-1:0]             lh_reg;
    logic [H_W-1:0]             rh_reg;

    logic           out_valid_reg;
    logic [H_W-1:0] left_height_reg;
    logic [H_W-1:0] right_height_reg;

    logic             stereo_c;
    logic             use_left_c;
    logic             use_right_c;
    logic [1:0]       eff_bytes_c;
    logic [MAG_W-1:0] mag_c;
    logic [2*MAG_W-1:0] sq_full_c;
    logic             frame_done_c;
    logic [FC_W-1:0]  fc_inc_c;
    logic [FC_W-1:0]  frames_c;
    logic [M_W-1:0]   m_c;
    logic [SUM_W-1:0] s_c;
    logic [H_W-1:0]   t_c;
    logic [LHS_W-1:0] lhs_c;
    logic             fit_c;
    logic [H_W-1:0]   h_new_c;

    assign stereo_c    = (chan_count_reg == rlm_pkg::CHANNELS_STEREO);
    assign use_left_c  = left_en_reg;
    assign use_right_c = stereo_c & right_en_reg;
    assign eff_bytes_c = (sample_bytes_reg == 2'd0) ? rlm_pkg::BYTES_ONE : sample_bytes_reg;

    always_comb
    begin
        logic [15:0] v16;
        logic [23:0] v24;
        v16 = sample[15:0];
        v24 = sample[23:0];
        case (eff_bytes_c)
            rlm_pkg::BYTES_ONE: mag_c = MAG_W'(sample[7:0]);
            rlm_pkg::BYTES_TWO:
            begin
                mag_c = MAG_W'(v16[15] ? 16'(~v16 + 16'd1) : v16);
            end
            default:
            begin
                mag_c = MAG_W'(v24[23] ? 24'(~v24 + 24'd1) : v24);
            end
        endcase
    end

    assign sq_full_c = mag_reg * mag_reg;

    // a frame closes on the second sample in stereo, on every sample in mono
    assign frame_done_c = !stereo_c || phase_reg;
    assign fc_inc_c     = fc_reg + FC_W'(1);

    always_comb
    begin
        frames_c = (block_frames_reg == '0) ? FC_W'(1) : block_frames_reg;
        if (32'(frames_c) > rlm_pkg::MAX_BLOCK_FRAMES)
        begin
            frames_c = FC_W'(rlm_pkg::MAX_BLOCK_FRAMES);
        end
    end

    always_comb
    begin
        logic [rlm_pkg::M_BASE_W-1:0] base;
        base = (use_left_c && use_right_c) ? rlm_pkg::M_STEREO : rlm_pkg::M_SINGLE;
        case (eff_bytes_c)
            rlm_pkg::BYTES_ONE: m_c = M_W'(base);
            rlm_pkg::BYTES_TWO: m_c = M_W'(base) << 8;
            default:            m_c = M_W'(base) << 16;
        endcase
    end

    assign s_c     = chan_reg ? rsum_reg : lsum_reg;
    assign t_c     = h_reg | (H_W'(1) << bit_reg);
    assign lhs_c   = (LHS_W'(phi_reg) << WORD_W) + LHS_W'(plo_reg);
    assign fit_c   = (lhs_c <= LHS_W'(rhs_reg));
    assign h_new_c = fit_c ? t_c : h_reg;

    assign status.block_done = frame_done_c && (fc_inc_c >= frames_c);
    assign status.bit_last   = (bit_reg == '0);
    assign status.chan_last  = chan_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_en_reg      <= 1'b1;
            right_en_reg     <= 1'b0;
            chan_count_reg   <= 2'd2;
            sample_bytes_reg <= 2'd2;
            block_frames_reg <= FC_W'(882);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rlm_pkg::CFG_LEFT_ENABLE:   left_en_reg      <= cfg_data[0];
                rlm_pkg::CFG_RIGHT_ENABLE:  right_en_reg     <= cfg_data[0];
                rlm_pkg::CFG_CHANNEL_COUNT: chan_count_reg   <= cfg_data[1:0];
                rlm_pkg::CFG_SAMPLE_BYTES:  sample_bytes_reg <= cfg_data[1:0];
                rlm_pkg::CFG_BLOCK_FRAMES:  block_frames_reg <= cfg_data[FC_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsum_reg      <= '0;
            rsum_reg      <= '0;
            fc_reg        <= '0;
            phase_reg     <= 1'b0;
            chan_reg      <= 1'b0;
            bit_reg       <= '0;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                rlm_pkg::OP_ACCUM:
                begin
                    if (!phase_reg || !stereo_c)
                    begin
                        if (use_left_c)
                        begin
                            lsum_reg <= lsum_reg + SUM_W'(sqs_reg);
                        end
                    end
                    else if (use_right_c)
                    begin
                        rsum_reg <= rsum_reg + SUM_W'(sqs_reg);
                    end
                    phase_reg <= stereo_c && !phase_reg;
                    if (frame_done_c)
                    begin
                        fc_reg <= fc_inc_c;
                    end
                end
                rlm_pkg::OP_RHS_HI:
                begin
                    h_reg   <= '0;
                    bit_reg <= BIT_W'(H_W - 1);
                end
                rlm_pkg::OP_CMP:
                begin
                    h_reg <= h_new_c;
                    if (bit_reg == '0)
                    begin
                        chan_reg <= !chan_reg;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - BIT_W'(1);
                    end
                end
                rlm_pkg::OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    lsum_reg      <= '0;
                    rsum_reg      <= '0;
                    fc_reg        <= '0;
                    phase_reg     <= 1'b0;
                    chan_reg      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            rlm_pkg::OP_LOAD:    mag_reg <= mag_c;
            rlm_pkg::OP_SQUARE:  sqs_reg <= sq_full_c[rlm_pkg::SQS_W-1:0];
            rlm_pkg::OP_RHS_LO:  rlo_reg <= s_c[WORD_W-1:0] * K2_C;
            rlm_pkg::OP_RHS_HI:  rhi_reg <= s_c[SUM_W-1:WORD_W] * K2_C;
            rlm_pkg::OP_RHS_SUM:
            begin
                rhs_reg <= (rlm_pkg::RHS_W'(rhi_reg) << WORD_W) + rlm_pkg::RHS_W'(rlo_reg);
            end
            rlm_pkg::OP_HM:      hm_reg  <= t_c * m_c;
            rlm_pkg::OP_SQ:      hsq_reg <= hm_reg * hm_reg;
            rlm_pkg::OP_MUL_LO:  plo_reg <= hsq_reg[WORD_W-1:0] * fc_reg;
            rlm_pkg::OP_MUL_HI:  phi_reg <= hsq_reg[rlm_pkg::HSQ_W-1:WORD_W] * fc_reg;
            rlm_pkg::OP_CMP:
            begin
                if (bit_reg == '0)
                begin
                    if (chan_reg)
                    begin
                        rh_reg <= h_new_c;
                    end
                    else
                    begin
                        lh_reg <= h_new_c;
                    end
                end
            end
            rlm_pkg::OP_EMIT:
            begin
                left_height_reg  <= use_left_c ? lh_reg : '0;
                right_height_reg <= use_right_c ? rh_reg : '0;
            end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign left_height  = left_height_reg;
    assign right_height = right_height_reg;

    `RLM_ASSERT_IMPLY(a_emit_no_overwrite, clk, rst_n, op == rlm_pkg::OP_EMIT, !out_valid_reg || out_ready)
    `RLM_ASSERT_IMPLY(a_search_has_frames, clk, rst_n, op == rlm_pkg::OP_HM, fc_reg != '0)
    `RLM_ASSERT_NEXT(a_block_end_count, clk, rst_n, op == rlm_pkg::OP_ACCUM && status.block_done, fc_reg != '0 && fc_reg <= FC_W'(rlm_pkg::MAX_BLOCK_FRAMES))

endmodule

>>> rtl/core/block_rms_level_meter.sv
// Block RMS level meter. Each request on samples carries one channel sample of an
// interleaved stream; a sample is taken in accept, square and accumulate steps.
// When a frame completes a block of block_frames frames, the block works out one
// bar height per channel, floor(76*sqrt(sum/frames)/M) saturated to 511, by a
// 9-step successive approximation that checks (h*M)^2*frames <= 76^2*sum in
// registered multiply/compare states per bit (HM, SQ, MUL_LO, MUL_HI, CMP), and
// no sample is taken until the result is in the output register. One result
// request per completed block; a trailing partial block is dropped. Write the
// configuration registers only while no block result is pending.
module block_rms_level_meter (
    input  logic     clk,
    input  logic     rst_n,
    rlm_in_if.sink   samples,
    rlm_out_if.source levels,
    rlm_cfg_if.sink  cfg
);

    rlm_pkg::dp_op_t     op;
    rlm_pkg::dp_status_t status;
    logic                in_ready;

    assign samples.ready = in_ready;
    assign cfg.ready     = 1'b1;

    rlm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    rlm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .sample       (samples.sample),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_ready    (levels.ready),
        .out_valid    (levels.valid),
        .left_height  (levels.left_height),
        .right_height (levels.right_height)
    );

endmodule

>>> dv/tb.sv
module tb;
    import rlm_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int IDLE_WAIT   = 120;
    localparam int DRAIN_WAIT  = 150;
    localparam int RUN_LIMIT   = 10_000_000;
    localparam int RAND_PHASES = 16;
    localparam int PHASE_ITEMS = 40;
    localparam int LONG_BLOCK  = 8191;
    localparam int MAX_REPORTS = 100;

    localparam logic [63:0] K_SQ = 64'd5776;   // 76 squared

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [1:0] CHANNELS_NONE = 2'd0;
    localparam logic [1:0] CHANNELS_MONO = 2'd1;
    localparam logic [1:0] CHANNELS_ODD  = 2'd3;
    localparam logic [1:0] BYTES_ZERO    = 2'd0;
    localparam logic [1:0] BYTES_THREE   = 2'd3;

    typedef struct packed {
        logic [HEIGHT_W-1:0] left;
        logic [HEIGHT_W-1:0] right;
    } heights_t;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [SAMPLE_W-1:0] val;
        bit                  typed;
        heights_t            want;
    } row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_LONG
    } stall_mode_t;

    logic clk;
    logic rst_n;

    rlm_in_if  samples_bus ();
    rlm_out_if levels_bus ();
    rlm_cfg_if cfg_bus ();

    block_rms_level_meter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_bus),
        .levels  (levels_bus),
        .cfg     (cfg_bus)
    );

    // register mirror
    bit                  cfg_left   = 1'b1;
    bit                  cfg_right  = 1'b0;
    logic [1:0]          cfg_chans  = CHANNELS_STEREO;
    logic [1:0]          cfg_bytes  = BYTES_TWO;
    logic [FC_W-1:0]     cfg_frames = 13'd882;

    // running block state
    logic [63:0] sum_left    = '0;
    logic [63:0] sum_right   = '0;
    int unsigned frames_done = 0;
    bit          second_next = 1'b0;

    heights_t levels_due[$];
    row_t     dir_rows[$];
    int       errors = 0;

    int          stall_left = 0;
    stall_mode_t stall_mode = RDY_ALWAYS;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic logic [63:0] square_of(input logic [SAMPLE_W-1:0] raw,
                                              input logic [1:0] bytes);
        logic [15:0] v16;
        logic [63:0] mag;
        if (bytes == BYTES_ZERO || bytes == BYTES_ONE) begin
            mag = {56'd0, raw[7:0]};
        end else if (bytes == BYTES_TWO) begin
            v16 = raw[15:0];
            mag = {48'd0, (v16[15] ? 16'd0 - v16 : v16)};
        end else begin
            mag = {40'd0, (raw[23] ? 24'd0 - raw : raw)};
        end
        return mag * mag;
    endfunction

    // largest h with (h*m)^2 * n <= 76^2 * s, found bit by bit
    function automatic logic [HEIGHT_W-1:0] height_of(input logic [63:0] s,
                                                      input logic [31:0] n,
                                                      input logic [31:0] m);
        logic [127:0]        rhs;
        logic [127:0]        lhs;
        logic [63:0]         hm;
        logic [63:0]         hsq;
        logic [HEIGHT_W-1:0] h;
        logic [HEIGHT_W-1:0] t;
        int                  b;
        rhs = K_SQ * s;
        h = '0;
        for (b = HEIGHT_W - 1; b >= 0; b--) begin
            t = h | (9'd1 << b);
            hm = t * m;
            hsq = hm * hm;
            lhs = hsq * n;
            if (lhs <= rhs)
                h = t;
        end
        return h;
    endfunction

    function automatic bit meter_step(input logic [SAMPLE_W-1:0] x, output heights_t res);
        bit          stereo;
        bit          use_l;
        bit          use_r;
        bit          frame_end;
        logic [63:0] sq;
        logic [31:0] m;
        int unsigned len;
        int unsigned shift;
        stereo = (cfg_chans == CHANNELS_STEREO);
        use_r = stereo && cfg_right;
        use_l = cfg_left;
        sq = square_of(x, cfg_bytes);
        res = '0;
        if (!stereo)
            second_next = 1'b0;
        if (!second_next) begin
            if (use_l)
                sum_left += sq;
            frame_end = !stereo;
            second_next = stereo;
        end else begin
            if (use_r)
                sum_right += sq;
            second_next = 1'b0;
            frame_end = 1'b1;
        end
        if (!frame_end)
            return 1'b0;
        frames_done++;
        len = (cfg_frames == '0) ? 1 : cfg_frames;
        if (frames_done < len)
            return 1'b0;
        shift = 8 * (((cfg_bytes == BYTES_ZERO) ? 1 : cfg_bytes) - 1);
        m = {25'd0, ((use_l && use_r) ? M_STEREO : M_SINGLE)} << shift;
        res.left = use_l ? height_of(sum_left, frames_done, m) : '0;
        res.right = use_r ? height_of(sum_right, frames_done, m) : '0;
        sum_left = '0;
        sum_right = '0;
        frames_done = 0;
        second_next = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 15))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            4:       return {w[7:0], 16'h8000};
            5:       return {w[15:0], 8'h80};
            6:       return {w[7:0], 16'h7FFF};
            default: return w[SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        row_t row;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.val = {11'd0, val};
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_sample(input logic [SAMPLE_W-1:0] val, input bit typed,
                              input int l, input int r);
        row_t row;
        row.kind = ROW_SAMPLE;
        row.idx = '0;
        row.val = val;
        row.typed = typed;
        row.want.left = l[HEIGHT_W-1:0];
        row.want.right = r[HEIGHT_W-1:0];
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            CFG_LEFT_ENABLE:   cfg_left = val[0];
            CFG_RIGHT_ENABLE:  cfg_right = val[0];
            CFG_CHANNEL_COUNT: cfg_chans = val[1:0];
            CFG_SAMPLE_BYTES:  cfg_bytes = val[1:0];
            CFG_BLOCK_FRAMES:  cfg_frames = val[FC_W-1:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input bit typed,
                               input heights_t want);
        heights_t got;
        samples_bus.valid <= 1'b1;
        samples_bus.sample <= x;
        do @(posedge clk); while (!samples_bus.ready);
        if (meter_step(x, got))
            levels_due.push_back(typed ? want : got);
    endtask

    // no write while a block end may still be in the search
    task automatic settle_idle();
        samples_bus.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // result side stalls in stretches of varying shape
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(8, 64);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            RDY_ALWAYS: levels_bus.ready <= 1'b1;
            RDY_COIN:   levels_bus.ready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE: levels_bus.ready <= (stall_left % 8 == 0);
            default:    levels_bus.ready <= (stall_left % 32 >= 16);
        endcase
    end

    always @(posedge clk) begin
        heights_t want;
        if (rst_n && levels_bus.valid && levels_bus.ready) begin
            if (levels_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual left %0d right %0d",
                             $time, levels_bus.left_height, levels_bus.right_height);
            end else begin
                want = levels_due.pop_front();
                if (levels_bus.left_height !== want.left) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: left_height expected %0d actual %0d",
                                 $time, want.left, levels_bus.left_height);
                end
                if (levels_bus.right_height !== want.right) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: right_height expected %0d actual %0d",
                                 $time, want.right, levels_bus.right_height);
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int                    burst;
        int                    gap;
        int                    pause_at;
        logic [CFG_DATA_W-1:0] d;
        logic [SAMPLE_W-1:0]   x;
        int unsigned           r;

        samples_bus.valid = 1'b0;
        samples_bus.sample = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        levels_bus.ready = 1'b0;
        rst_n = 1'b0;

        // mono, 8-bit, zero block length taken as one
        add_cfg(CFG_CHANNEL_COUNT, CHANNELS_MONO);
        add_cfg(CFG_BLOCK_FRAMES, 13'd0);
        add_cfg(CFG_SAMPLE_BYTES, BYTES_ONE);
        add_cfg(CFG_UNUSED, 13'h1FFF);
        add_sample(24'h0000FF, 1'b1, 307, 0);
        add_sample(24'h000000, 1'b1, 0, 0);
        add_sample(24'hFFFF00, 1'b1, 0, 0);
        add_sample(24'h7FFF80, 1'b1, 154, 0);
        // zero sample width acts as one byte
        add_cfg(CFG_SAMPLE_BYTES, BYTES_ZERO);
        add_sample(24'h0000FF, 1'b1, 307, 0);
        add_cfg(CFG_BLOCK_FRAMES, 13'd1);
        add_cfg(CFG_SAMPLE_BYTES, BYTES_TWO);
        add_sample(24'h008000, 1'b1, 154, 0);
        add_sample(24'h007FFF, 1'b1, 154, 0);
        add_cfg(CFG_SAMPLE_BYTES, BYTES_THREE);
        add_sample(24'h800000, 1'b1, 154, 0);
        add_sample(24'h7FFFFF, 1'b1, 154, 0);
        add_sample(24'hFFFFFF, 1'b1, 0, 0);
        // stereo: with both channels enabled, both use the larger reference
        add_cfg(CFG_CHANNEL_COUNT, CHANNELS_STEREO);
        add_cfg(CFG_RIGHT_ENABLE, 13'd1);
        add_cfg(CFG_SAMPLE_BYTES, BYTES_ONE);
        add_sample(24'h0000FF, 1'b0, 0, 0);
        add_sample(24'h0000FF, 1'b1, 152, 152);
        add_sample(24'h00007F, 1'b0, 0, 0);
        add_sample(24'h000000, 1'b1, 76, 0);
        add_cfg(CFG_LEFT_ENABLE, 13'd0);
        add_sample(24'h0000FF, 1'b0, 0, 0);
        add_sample(24'h0000FF, 1'b1, 0, 307);
        // both off: frames still counted, zero heights
        add_cfg(CFG_RIGHT_ENABLE, 13'd0);
        add_sample(24'h000012, 1'b0, 0, 0);
        add_sample(24'h000034, 1'b1, 0, 0);
        // non-stereo channel counts (3 and 0) are mono, right ignored
        add_cfg(CFG_LEFT_ENABLE, 13'd1);
        add_cfg(CFG_RIGHT_ENABLE, 13'd1);
        add_cfg(CFG_CHANNEL_COUNT, CHANNELS_ODD);
        add_sample(24'h0000FF, 1'b1, 307, 0);
        add_cfg(CFG_CHANNEL_COUNT, CHANNELS_NONE);
        add_sample(24'h00007F, 1'b1, 153, 0);
        // block length shortened inside a block
        add_cfg(CFG_BLOCK_FRAMES, 13'd3);
        add_sample(24'h0000FF, 1'b0, 0, 0);
        add_cfg(CFG_BLOCK_FRAMES, 13'd2);
        add_sample(24'h000000, 1'b0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].val[CFG_DATA_W-1:0]);
            end else begin
                send_sample(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle_idle();
            d = $urandom;
            d[0] = ($urandom_range(0, 3) != 0);
            write_reg(CFG_LEFT_ENABLE, d);
            d = $urandom;
            d[0] = ($urandom_range(0, 3) != 0);
            write_reg(CFG_RIGHT_ENABLE, d);
            d = $urandom;
            r = $urandom_range(0, 7);
            d[1:0] = (r < 5) ? CHANNELS_STEREO : 2'($urandom_range(0, 3));
            write_reg(CFG_CHANNEL_COUNT, d);
            d = $urandom;
            write_reg(CFG_SAMPLE_BYTES, d);
            r = $urandom_range(0, 9);
            if (r == 0)
                d = '0;
            else if (r == 1)
                d = $urandom_range(7, 40);
            else
                d = $urandom_range(1, 5);
            write_reg(CFG_BLOCK_FRAMES, d);

            pause_at = $urandom_range(0, PHASE_ITEMS - 1);
            burst = $urandom_range(1, 20);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == pause_at && levels_due.size() != 0) begin
                    // hold requests until the result side has drained
                    samples_bus.valid <= 1'b0;
                    while (levels_due.size() != 0)
                        @(posedge clk);
                end else if (burst <= 0) begin
                    gap = $urandom_range(0, 12);
                    if (gap != 0) begin
                        samples_bus.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst = $urandom_range(1, 20);
                end
                burst--;
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        // one full-length mono block near full scale
        settle_idle();
        write_reg(CFG_LEFT_ENABLE, 13'd1);
        write_reg(CFG_CHANNEL_COUNT, CHANNELS_MONO);
        write_reg(CFG_SAMPLE_BYTES, BYTES_THREE);
        write_reg(CFG_BLOCK_FRAMES, 13'd8191);
        burst = $urandom_range(50, 400);
        for (int i = 0; i < LONG_BLOCK; i++) begin
            if (burst <= 0) begin
                gap = $urandom_range(1, 2);
                samples_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst = $urandom_range(50, 400);
            end
            burst--;
            r = $urandom_range(0, 3);
            if (r == 0)
                x = random_sample();
            else
                x = (r == 1) ? 24'h800000 : 24'h7FFFFF;
            send_sample(x, 1'b0, '0);
        end

        samples_bus.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
